[sv/softmax_cross_entropy_row_macros.svh]
// assertion macros shared by the checker
`ifndef SOFTMAX_CROSS_ENTROPY_ROW_MACROS_SVH
`define SOFTMAX_CROSS_ENTROPY_ROW_MACROS_SVH
// implication checked every clock, quiet in reset
`define SCE_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sce check failed");
// next-cycle implication
`define SCE_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sce check failed");
`endif

[sv/sce_pkg.sv]
// ---------------------------------------------------------------------------
// sce_pkg
// types, constants and lookup tables for the softmax cross-entropy row block
// ---------------------------------------------------------------------------
`default_nettype none
package sce_pkg;
   localparam int MAX_CLASSES = 32;
   localparam logic [0:0] CSR_CLASS_COUNT = 1'b0;
   localparam logic [0:0] CSR_GRAD_ENABLE = 1'b1;
   localparam logic [25:0] LOSS_MAX = 26'h3FFFFFF;

   // datapath commands
   typedef struct packed {
      logic load;       // store one beat at load index
      logic clear_row;  // restart running max
      logic sum_clear;
      logic exp_go;     // exp of read entry, valid next cycle
      logic sum_add;
      logic div_start;
      logic ln_go;
      logic acc_clear;
      logic acc_add;
      logic [4:0] idx;
   } ctrl_type;

   typedef struct packed {
      logic div_done;
   } stat_type;

   function automatic logic [16:0] pow2_tab(input logic [4:0] k);
      logic [16:0] r;
      case (k)
         5'd0: r = 17'd65536; 5'd1: r = 17'd62757; 5'd2: r = 17'd60097;
         5'd3: r = 17'd57549; 5'd4: r = 17'd55109; 5'd5: r = 17'd52773;
         5'd6: r = 17'd50535; 5'd7: r = 17'd48393; 5'd8: r = 17'd46341;
         5'd9: r = 17'd44376; 5'd10: r = 17'd42495; 5'd11: r = 17'd40693;
         5'd12: r = 17'd38968; 5'd13: r = 17'd37316; 5'd14: r = 17'd35734;
         5'd15: r = 17'd34219; 5'd16: r = 17'd32768;
         default: r = 17'd32768;
      endcase
      return r;
   endfunction

   function automatic logic [16:0] log2_tab(input logic [4:0] k);
      logic [16:0] r;
      case (k)
         5'd0: r = 17'd0; 5'd1: r = 17'd5732; 5'd2: r = 17'd11136;
         5'd3: r = 17'd16248; 5'd4: r = 17'd21098; 5'd5: r = 17'd25711;
         5'd6: r = 17'd30109; 5'd7: r = 17'd34312; 5'd8: r = 17'd38336;
         5'd9: r = 17'd42196; 5'd10: r = 17'd45904; 5'd11: r = 17'd49472;
         5'd12: r = 17'd52911; 5'd13: r = 17'd56229; 5'd14: r = 17'd59434;
         5'd15: r = 17'd62534; 5'd16: r = 17'd65536;
         default: r = 17'd65536;
      endcase
      return r;
   endfunction
endpackage
`default_nettype wire

[sv/sce_ram.sv]
// ---------------------------------------------------------------------------
// sce_ram
// generic single-port-write ram with registered read
// ---------------------------------------------------------------------------
`default_nettype none
module sce_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

[sv/sce_datapath.sv]
// ---------------------------------------------------------------------------
// sce_datapath
// stores, running max, exp, sum, serial divider, log and loss accumulator
// ---------------------------------------------------------------------------
`default_nettype none
module sce_datapath (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire sce_pkg::ctrl_type ctrl,
   input  wire logic [15:0]       req_logit_value,
   input  wire logic [15:0]       req_label_value,
   output sce_pkg::stat_type      stat,
   output logic [16:0]            grad,
   output logic [25:0]            loss
);
   import sce_pkg::*;
   localparam int AW = $clog2(MAX_CLASSES);

   logic [15:0] logit_rd, label_rd;
   logic [AW-1:0] addr;
   assign addr = ctrl.idx[AW-1:0];

   sce_ram #(.WIDTH(16), .DEPTH(MAX_CLASSES)) u_logit (
      .clock, .wr_en(ctrl.load), .wr_addr(addr), .wr_data(req_logit_value),
      .rd_addr(addr), .rd_data(logit_rd));
   sce_ram #(.WIDTH(16), .DEPTH(MAX_CLASSES)) u_label (
      .clock, .wr_en(ctrl.load), .wr_addr(addr), .wr_data(req_label_value),
      .rd_addr(addr), .rd_data(label_rd));

   // running max
   logic signed [15:0] max_ff, max_in;
   always_comb begin
      max_in = max_ff;
      if (ctrl.load && $signed(req_logit_value) > max_ff) max_in = $signed(req_logit_value);
      if (ctrl.clear_row) max_in = 16'sh8000;
   end
   always_ff @(posedge clock) begin
      if (reset) max_ff <= 16'sh8000;
      else max_ff <= max_in;
   end

   // exp stage 1: d * log2(e)
   logic [16:0] d;
   logic [25:0] t;
   logic [25:0] t_ff;
   logic [15:0] lab_ff;
   assign d = 17'($signed({max_ff[15], max_ff}) - $signed({logit_rd[15], logit_rd}));
   assign t = 26'((26'(d) * 26'd369) >> 8);
   always_ff @(posedge clock) begin
      if (ctrl.exp_go) begin
         t_ff <= t;
         lab_ff <= label_rd;
      end
   end

   // exp stage 2: table interpolation and shift
   logic [17:0] ip;
   logic [3:0] hi, lo;
   logic [16:0] ta, tb, v;
   logic [16:0] e;
   assign ip = t_ff[25:8];
   assign hi = t_ff[7:4];
   assign lo = t_ff[3:0];
   assign ta = pow2_tab({1'b0, hi});
   assign tb = pow2_tab(5'({1'b0, hi} + 5'd1));
   assign v = 17'(ta - 17'((21'(ta - tb) * 21'(lo)) >> 4));
   assign e = (ip > 18'd16) ? 17'd0 : 17'(v >> ip[4:0]);

   logic [22:0] sum_ff;
   always_ff @(posedge clock) begin
      if (ctrl.sum_clear) sum_ff <= '0;
      else if (ctrl.sum_add) sum_ff <= 23'(sum_ff + 23'(e));
   end

   // restoring divider, one quotient bit per cycle
   logic [39:0] num_ff;
   logic [23:0] rem_ff;
   logic [5:0]  cnt_ff;
   logic        busy_ff;
   logic [23:0] rem_sh;
   logic [24:0] rem_try;
   assign rem_sh = {rem_ff[22:0], num_ff[39]};
   assign rem_try = {1'b0, rem_sh} - {2'b0, sum_ff};
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else if (ctrl.div_start) begin
         busy_ff <= 1'b1;
         cnt_ff <= 6'd40;
         num_ff <= 40'({e, 15'd0}) + 40'(sum_ff >> 1);
         rem_ff <= '0;
      end else if (busy_ff) begin
         if (!rem_try[24]) begin
            rem_ff <= rem_try[23:0];
            num_ff <= {num_ff[38:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            num_ff <= {num_ff[38:0], 1'b0};
         end
         cnt_ff <= cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) busy_ff <= 1'b0;
      end
   end
   assign stat.div_done = busy_ff && (cnt_ff == 6'd1);

   // probability, valid when divider idle after a run
   logic [15:0] p;
   assign p = num_ff[15:0];
   assign grad = 17'($signed({1'b0, p}) - $signed({1'b0, lab_ff}));

   // log stage 1: normalize and interpolate
   logic [3:0] m;
   logic [15:0] pc, x, f;
   always_comb begin
      pc = (p == 16'd0) ? 16'd1 : p;
      m = 4'd0;
      for (int i = 1; i < 16; i++) if (pc[i]) m = 4'(i);
   end
   assign x = 16'(pc << (4'd15 - m));
   assign f = x - 16'd32768;
   logic [16:0] la, lb;
   logic [20:0] lg;
   assign la = log2_tab({1'b0, f[14:11]});
   assign lb = log2_tab(5'({1'b0, f[14:11]} + 5'd1));
   assign lg = 21'({m, 16'd0}) + 21'(la) + 21'((28'(lb - la) * 28'(f[10:0])) >> 11);
   logic [20:0] n2_ff;
   logic [15:0] lab2_ff;
   always_ff @(posedge clock) begin
      if (ctrl.ln_go) begin
         n2_ff <= 21'(21'(15 * 65536) - lg);
         lab2_ff <= lab_ff;
      end
   end

   // log stage 2: scale to natural log
   logic [20:0] nl;
   assign nl = 21'((37'(n2_ff) * 37'd45426 + 37'd32768) >> 16);
   logic [20:0] nl_ff;
   logic [15:0] lab3_ff;
   logic        add1_ff;
   logic        add2_ff;
   // after ln_go the term is registered in n2_ff, then in nl_ff
   always_ff @(posedge clock) begin
      if (reset) begin
         add1_ff <= 1'b0;
         add2_ff <= 1'b0;
      end else begin
         add1_ff <= ctrl.acc_add;
         add2_ff <= add1_ff;
      end
      nl_ff <= nl;
      lab3_ff <= lab2_ff;
   end

   logic [42:0] acc_ff;
   always_ff @(posedge clock) begin
      if (ctrl.acc_clear) acc_ff <= '0;
      else if (add2_ff) acc_ff <= 43'(acc_ff + 43'(37'(lab3_ff) * 37'(nl_ff)));
   end

   logic [42:0] lr;
   assign lr = 43'(acc_ff + 43'd16384) >> 15;
   assign loss = (lr > 43'(LOSS_MAX)) ? LOSS_MAX : lr[25:0];
endmodule
`default_nettype wire

[sv/sce_control.sv]
// ---------------------------------------------------------------------------
// sce_control
// sequencer: load, sum pass, divide/log pass with gradient beats, loss beat
// ---------------------------------------------------------------------------
`default_nettype none
module sce_control (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_wr_en,
   input  wire logic [0:0]        csr_index,
   input  wire logic [5:0]        csr_wr_data,
   input  wire logic              req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic                   rsp_kind,
   output logic [4:0]             rsp_class_index,
   output logic                   rsp_last,
   output logic                   grad_sel,
   input  wire sce_pkg::stat_type stat,
   output sce_pkg::ctrl_type      ctrl
);
   import sce_pkg::*;
   localparam int CW = $clog2(MAX_CLASSES + 1);

   localparam logic [3:0] S_LOAD  = 4'd0;
   localparam logic [3:0] S_SRD   = 4'd1; // read for sum
   localparam logic [3:0] S_SEXP  = 4'd2;
   localparam logic [3:0] S_SADD  = 4'd3;
   localparam logic [3:0] S_PRD   = 4'd4;
   localparam logic [3:0] S_PEXP  = 4'd5;
   localparam logic [3:0] S_DIV   = 4'd6;
   localparam logic [3:0] S_WAIT  = 4'd7;
   localparam logic [3:0] S_LN    = 4'd8;
   localparam logic [3:0] S_GRAD  = 4'd9;
   localparam logic [3:0] S_FLUSH = 4'd10;
   localparam logic [3:0] S_FLUSH2= 4'd11;
   localparam logic [3:0] S_LOSS  = 4'd12;

   logic [3:0] st_ff, st_in;
   logic [5:0] cc_ff;
   logic ge_ff, gr_ff, gr_in;
   logic [CW-1:0] cnt_ff, cnt_in, n;

   always_comb begin
      if (cc_ff == 6'd0) n = CW'(1);
      else if (32'(cc_ff) > MAX_CLASSES) n = CW'(MAX_CLASSES);
      else n = CW'(cc_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cc_ff <= 6'd32;
         ge_ff <= 1'b1;
      end else if (csr_wr_en) begin
         if (csr_index == CSR_CLASS_COUNT) cc_ff <= csr_wr_data;
         else ge_ff <= csr_wr_data[0];
      end
   end

   logic last_idx;
   assign last_idx = (cnt_ff == CW'(n - CW'(1)));

   always_comb begin
      st_in = st_ff;
      cnt_in = cnt_ff;
      gr_in = gr_ff;
      ctrl = '0;
      ctrl.idx = 5'(cnt_ff);
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      rsp_kind = 1'b0;
      rsp_last = 1'b0;
      rsp_class_index = 5'(cnt_ff);
      grad_sel = 1'b1;
      case (st_ff)
         S_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctrl.load = 1'b1;
               if (cnt_ff + CW'(1) >= n) begin
                  cnt_in = '0;
                  ctrl.sum_clear = 1'b1;
                  gr_in = ge_ff;
                  st_in = S_SRD;
               end else if (32'(cnt_ff) < MAX_CLASSES - 1) begin
                  cnt_in = cnt_ff + CW'(1);
               end
            end
         end
         S_SRD: st_in = S_SEXP;
         S_SEXP: begin ctrl.exp_go = 1'b1; st_in = S_SADD; end
         S_SADD: begin
            ctrl.sum_add = 1'b1;
            if (last_idx) begin
               cnt_in = '0;
               ctrl.acc_clear = 1'b1;
               st_in = S_PRD;
            end else begin
               cnt_in = cnt_ff + CW'(1);
               st_in = S_SRD;
            end
         end
         S_PRD: begin st_in = S_PEXP; end
         S_PEXP: begin ctrl.exp_go = 1'b1; st_in = S_DIV; end
         S_DIV: begin ctrl.div_start = 1'b1; st_in = S_WAIT; end
         S_WAIT: if (stat.div_done) st_in = S_LN;
         S_LN: begin
            ctrl.ln_go = 1'b1;
            ctrl.acc_add = 1'b1;
            st_in = gr_ff ? S_GRAD : S_FLUSH;
         end
         S_GRAD: begin
            rsp_valid = 1'b1;
            if (rsp_ready) st_in = S_FLUSH;
         end
         S_FLUSH: begin
            if (last_idx) begin
               cnt_in = '0;
               st_in = S_FLUSH2;
            end else begin
               cnt_in = cnt_ff + CW'(1);
               st_in = S_PRD;
            end
         end
         S_FLUSH2: st_in = S_LOSS;  // accumulator settles
         S_LOSS: begin
            rsp_valid = 1'b1;
            rsp_kind = 1'b1;
            rsp_last = 1'b1;
            rsp_class_index = 5'd0;
            grad_sel = 1'b0;
            if (rsp_ready) begin
               ctrl.clear_row = 1'b1;
               st_in = S_LOAD;
            end
         end
         default: st_in = S_LOAD;
      endcase
      if (csr_wr_en && csr_index == CSR_CLASS_COUNT) begin
         ctrl.clear_row = 1'b1;
         cnt_in = '0;
         st_in = S_LOAD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_LOAD;
         cnt_ff <= '0;
         gr_ff <= 1'b1;
      end else begin
         st_ff <= st_in;
         cnt_ff <= cnt_in;
         gr_ff <= gr_in;
      end
   end
endmodule
`default_nettype wire

[sv/softmax_cross_entropy_row.sv]
// ---------------------------------------------------------------------------
// softmax_cross_entropy_row
// softmax cross-entropy loss and gradient over one row of classes
// ---------------------------------------------------------------------------
// Logits (Q8.8) and labels (Q1.15) load one class per beat at one beat per
// cycle while the block is loading. After the row's last beat the block makes
// a sum pass (read, exp and add states per class), then a probability pass
// with a bit-serial divide per class plus output stall, emitting one gradient
// beat per class if enabled, then the loss beat.
`default_nettype none
module softmax_cross_entropy_row (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [0:0]  csr_index,
   input  wire logic [5:0]  csr_wr_data,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [15:0] req_logit_value,
   input  wire logic [15:0] req_label_value,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_kind,
   output logic [4:0]       rsp_class_index,
   output logic [16:0]      rsp_grad_value,
   output logic [25:0]      rsp_loss_value,
   output logic             rsp_last
);
   import sce_pkg::*;
   ctrl_type ctrl;
   stat_type stat;
   logic grad_sel;
   logic [16:0] grad;
   logic [25:0] loss;

   sce_control u_ctl (
      .clock, .reset, .csr_wr_en, .csr_index, .csr_wr_data, .req_valid, .req_ready,
      .rsp_valid, .rsp_ready, .rsp_kind, .rsp_class_index, .rsp_last, .grad_sel,
      .stat, .ctrl);
   sce_datapath u_dp (
      .clock, .reset, .ctrl, .req_logit_value, .req_label_value, .stat,
      .grad, .loss);

   assign rsp_grad_value = grad_sel ? grad : 17'd0;
   assign rsp_loss_value = grad_sel ? 26'd0 : loss;
endmodule
`default_nettype wire

[sv/sce_checker.sv]
// ---------------------------------------------------------------------------
// sce_checker
// port-level checks on the row block
// ---------------------------------------------------------------------------
`default_nettype none
`include "softmax_cross_entropy_row_macros.svh"
module sce_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        rsp_kind,
   input wire logic        rsp_last,
   input wire logic [16:0] rsp_grad_value,
   input wire logic [25:0] rsp_loss_value
);
   `SCE_ASSERT_IMP(a_no_overlap, clock, reset, rsp_valid, !req_ready)
   `SCE_ASSERT_IMP(a_last_kind, clock, reset, rsp_valid, rsp_last == rsp_kind)
   `SCE_ASSERT_IMP(a_loss_zero_grad, clock, reset, rsp_valid && rsp_kind, rsp_grad_value == 17'd0)
   `SCE_ASSERT_IMP(a_grad_zero_loss, clock, reset, rsp_valid && !rsp_kind, rsp_loss_value == 26'd0)
   `SCE_ASSERT_NXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
endmodule
bind softmax_cross_entropy_row sce_checker u_chk (
   .clock, .reset, .req_ready, .rsp_valid, .rsp_ready, .rsp_kind, .rsp_last,
   .rsp_grad_value, .rsp_loss_value);
`default_nettype wire

[dv/tb_top.sv]
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the softmax cross-entropy row block
// ---------------------------------------------------------------------------
// Rows of logits and labels are fed through a queue-driven driver; a monitor
// stores every accepted input beat, predicts gradient and loss beats at each
// row end and checks each output beat in order. Row sizes, gradient mode and
// logit spread vary by phase, with random stalls on both channels.
module tb_top;
   import sce_pkg::*;

   localparam logic KIND_GRAD = 1'b0;
   localparam logic KIND_LOSS = 1'b1;
   localparam int   ROWS_MAX  = 32;

   localparam logic [16:0] POW2_Q16 [17] = '{
      65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393, 46341,
      44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768};
   localparam logic [16:0] LOG2_Q16 [17] = '{
      0, 5732, 11136, 16248, 21098, 25711, 30109, 34312, 38336,
      42196, 45904, 49472, 52911, 56229, 59434, 62534, 65536};

   typedef struct packed {
      logic [15:0] logit;
      logic [15:0] label;
   } class_beat_type;

   typedef struct packed {
      logic        kind;
      logic [4:0]  class_index;
      logic [16:0] grad;
      logic [25:0] loss;
      logic        last;
   } row_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [0:0]  csr_index = CSR_CLASS_COUNT;
   logic [5:0]  csr_wr_data = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [15:0] req_logit_value = '0;
   logic [15:0] req_label_value = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_kind;
   logic [4:0]  rsp_class_index;
   logic [16:0] rsp_grad_value;
   logic [25:0] rsp_loss_value;
   logic        rsp_last;

   class_beat_type pending_beats[$];
   row_result_type expected_results[$];

   // predictor state
   logic [15:0] logit_mem [ROWS_MAX];
   logic [15:0] label_mem [ROWS_MAX];
   int          loaded_cnt = 0;
   int          row_max = -32768;
   logic [5:0]  class_cnt_reg = 6'd32;
   logic        grad_en_reg = 1'b1;

   int  errors = 0;
   int  rows_done = 0;
   int  beats_checked = 0;
   int  items_sent = 0;
   bit  calm = 1'b0;
   bit  hold = 1'b0;

   always #6 clock = ~clock;

   softmax_cross_entropy_row DUT (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_logit_value(req_logit_value), .req_label_value(req_label_value),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_kind(rsp_kind),
      .rsp_class_index(rsp_class_index), .rsp_grad_value(rsp_grad_value),
      .rsp_loss_value(rsp_loss_value), .rsp_last(rsp_last)
   );

   function automatic logic [31:0] exp_q16(int lg, int mx);
      logic [31:0] d, t, ip, fr, hi, v;
      d  = mx - lg;
      t  = (d * 32'd369) >> 8;
      ip = t >> 8;
      fr = t & 32'd255;
      hi = fr >> 4;
      v  = POW2_Q16[hi] - (((POW2_Q16[hi] - POW2_Q16[hi + 1]) * (fr & 32'd15)) >> 4);
      return (ip > 16) ? 32'd0 : (v >> ip);
   endfunction

   function automatic logic [63:0] neg_ln_q16(logic [31:0] p);
      logic [31:0] m, x, f, hi, v, lg, n2;
      m = 0;
      if (p == 0) p = 1;   // clamp to eps
      while (m < 15 && (p >> (m + 1)) != 0) m++;
      x  = p << (15 - m);
      f  = x - 32'd32768;
      hi = f >> 11;
      v  = LOG2_Q16[hi] + (((LOG2_Q16[hi + 1] - LOG2_Q16[hi]) * (f & 32'd2047)) >> 11);
      lg = m * 32'd65536 + v;
      n2 = 32'd983040 - lg;
      return ({32'd0, n2} * 64'd45426 + 64'd32768) >> 16;
   endfunction

   function automatic int active_classes();
      if (class_cnt_reg == 0) return 1;
      if (class_cnt_reg > ROWS_MAX) return ROWS_MAX;
      return class_cnt_reg;
   endfunction

   // store one class and, at row end, queue gradient beats (if enabled) and the loss beat
   function automatic void load_class(class_beat_type b);
      int n, pos, lg;
      logic [31:0] sum, e, p;
      logic [63:0] acc, loss;
      row_result_type r;
      n = active_classes();
      pos = (loaded_cnt >= ROWS_MAX) ? ROWS_MAX - 1 : loaded_cnt;
      logit_mem[pos] = b.logit;
      label_mem[pos] = b.label;
      lg = $signed(b.logit);
      if (lg > row_max) row_max = lg;
      loaded_cnt = pos + 1;
      if (loaded_cnt < n) return;
      sum = 0;
      for (int j = 0; j < n; j++) sum += exp_q16($signed(logit_mem[j]), row_max);
      acc = 0;
      for (int j = 0; j < n; j++) begin
         e = exp_q16($signed(logit_mem[j]), row_max);
         p = 32'(({32'd0, e} * 64'd32768 + {33'd0, sum[31:1]}) / {32'd0, sum});
         acc += {48'd0, label_mem[j]} * neg_ln_q16(p);
         if (grad_en_reg) begin
            r.kind = KIND_GRAD;
            r.class_index = 5'(j);
            r.grad = 17'(int'(p) - int'(label_mem[j]));
            r.loss = '0;
            r.last = 1'b0;
            expected_results.push_back(r);
         end
      end
      loss = (acc + 64'd16384) >> 15;
      if (loss > 64'(LOSS_MAX)) loss = 64'(LOSS_MAX);
      r.kind = KIND_LOSS;
      r.class_index = '0;
      r.grad = '0;
      r.loss = loss[25:0];
      r.last = 1'b1;
      expected_results.push_back(r);
      loaded_cnt = 0;
      row_max = -32768;
      rows_done++;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (pending_beats.size() > 0 && !hold && (calm || $urandom_range(99) >= 17)) begin
            class_beat_type b;
            b = pending_beats.pop_front();
            req_valid <= 1'b1;
            req_logit_value <= b.logit;
            req_label_value <= b.label;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= calm || ($urandom_range(99) >= 17);
   end

   // monitor and checker
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            load_class('{logit: req_logit_value, label: req_label_value});
            items_sent++;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected beat kind=%0d idx=%0d grad=%0d loss=%0d",
                        $time, rsp_kind, rsp_class_index, rsp_grad_value, rsp_loss_value);
               errors++;
            end else begin
               row_result_type x;
               x = expected_results.pop_front();
               beats_checked++;
               if (rsp_kind !== x.kind) begin
                  $display("%0t: kind exp %0d got %0d", $time, x.kind, rsp_kind); errors++;
               end
               if (rsp_class_index !== x.class_index) begin
                  $display("%0t: class_index exp %0d got %0d", $time, x.class_index,
                           rsp_class_index); errors++;
               end
               if (rsp_grad_value !== x.grad) begin
                  $display("%0t: grad exp %0d got %0d", $time, $signed(x.grad),
                           $signed(rsp_grad_value)); errors++;
               end
               if (rsp_loss_value !== x.loss) begin
                  $display("%0t: loss exp %0d got %0d", $time, x.loss, rsp_loss_value);
                  errors++;
               end
               if (rsp_last !== x.last) begin
                  $display("%0t: last exp %0d got %0d", $time, x.last, rsp_last); errors++;
               end
            end
         end
      end
   end

   task automatic wait_drained();
      @(negedge clock);
      while (pending_beats.size() > 0 || req_valid || expected_results.size() > 0)
         @(negedge clock);
      // block may still hold a partial row
      repeat (40) @(negedge clock);
   endtask

   task automatic write_csr(logic [0:0] idx, logic [5:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= val;
      if (idx == CSR_CLASS_COUNT) begin
         class_cnt_reg = val;
         loaded_cnt = 0;
         row_max = -32768;
      end else begin
         grad_en_reg = val[0];
      end
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic push_beat(logic [15:0] lg, logic [15:0] lb);
      pending_beats.push_back('{logit: lg, label: lb});
   endtask

   initial begin
      int n, rows, spread, base;
      logic [15:0] lb;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // default config: full 32-class row with gradients
      for (int j = 0; j < 32; j++) push_beat(16'(j * 37 - 600), (j == 3) ? 16'd32768 : 16'd0);
      wait_drained();

      // single class row, extremes of logit and label
      write_csr(CSR_CLASS_COUNT, 6'd1);
      push_beat(16'h7FFF, 16'd32768);
      push_beat(16'h8000, 16'd65535);
      wait_drained();
      // two classes far apart: zero probability clamps to eps
      write_csr(CSR_CLASS_COUNT, 6'd2);
      push_beat(16'h8000, 16'd32768);
      push_beat(16'h7FFF, 16'd0);
      push_beat(16'hFFFF, 16'd16384);
      push_beat(16'h0000, 16'd16384);
      wait_drained();
      // zero class count acts as one, loss-only mode
      write_csr(CSR_GRAD_ENABLE, 1'b0);
      write_csr(CSR_CLASS_COUNT, 6'd0);
      push_beat(16'h1234, 16'd32768);
      wait_drained();
      // count above the store size acts as full
      write_csr(CSR_GRAD_ENABLE, 1'b1);
      write_csr(CSR_CLASS_COUNT, 6'd63);
      // partial row then a count write abandons it
      push_beat(16'h0100, 16'd100);
      push_beat(16'h0200, 16'd200);
      wait_drained();
      write_csr(CSR_CLASS_COUNT, 6'd3);
      push_beat(16'h0080, 16'd0);
      wait_drained();
      // gradient mode flipped mid-row counts at row end
      write_csr(CSR_GRAD_ENABLE, 1'b0);
      push_beat(16'hFF00, 16'd32768);
      push_beat(16'h0300, 16'd0);
      wait_drained();

      // random phases, the middle ones without stalls
      for (int ph = 0; ph < 5 || items_sent < 110; ph++) begin
         calm = (ph == 3 || ph == 4);
         n = ($urandom_range(9) == 0) ? 32 : $urandom_range(1, 6);
         if (ph == 1) n = 32;
         write_csr(CSR_CLASS_COUNT, 6'(n));
         write_csr(CSR_GRAD_ENABLE, 1'($urandom_range(1)));
         rows = (n > 8) ? 1 : $urandom_range(2, 5);
         spread = $urandom_range(3);
         hold = (ph == 2);
         for (int r = 0; r < rows; r++) begin
            base = $urandom_range(65535);
            for (int j = 0; j < n; j++) begin
               case ($urandom_range(9))
                  0: lb = 16'($urandom_range(65535));
                  1: lb = 16'd32768;
                  2: lb = 16'd0;
                  default: lb = 16'($urandom_range(32768));
               endcase
               if (spread == 0) push_beat(16'($urandom_range(65535)), lb);
               else push_beat(16'(base + $urandom_range(1 << (6 + 2 * spread))), lb);
            end
         end
         // occasionally leave a trailing partial row
         if (n > 1 && $urandom_range(5) == 0) push_beat(16'($urandom_range(65535)), 16'd7);
         if (hold) begin
            repeat (20) @(negedge clock);
            hold = 1'b0;
         end
         wait_drained();
      end
      calm = 1'b0;
      wait_drained();

      $display("covered %0d input beats over %0d rows, %0d result beats checked",
               items_sent, rows_done, beats_checked);
      $display("row sizes 1..32, count wrap cases, loss-only and gradient modes");
      if (errors == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

   initial begin
      #30000000;
      $display("timeout with %0d results outstanding", expected_results.size());
      $display("== FAIL ==");
      $finish;
   end
endmodule

[files.f]
+incdir+sv
sv/sce_pkg.sv
sv/sce_ram.sv
sv/sce_datapath.sv
sv/sce_control.sv
sv/softmax_cross_entropy_row.sv
sv/sce_checker.sv
dv/tb_top.sv
